[design/ldf_pkg.sv]
// ---------------------------------------------------------------------------
// ldf_pkg: shared types for the luma deblocking edge filter
// filter mode codes, per-segment decision bundle and pixel lane constants
// ---------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

  // number of lines in one edge segment, one filter lane each
  localparam int LANES = 4;

  // pixel lanes are 8 bits wide, so results clip to 255 at any depth
  localparam logic [7:0] PIX_MAX = 8'hFF;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_NORMAL = 2'd1,
    MODE_STRONG = 2'd2
  } mode_t;

  // what lines 0 and 3 decide for the whole segment
  typedef struct packed {
    mode_t mode;
    logic  two_p;
    logic  two_q;
  } dec_t;

endpackage

`default_nettype wire

[design/luma_deblocking_edge_filter.sv]
// ---------------------------------------------------------------------------
// luma_deblocking_edge_filter: luma deblocking of one four-line edge segment
// decides the filter mode from lines 0 and 3, then filters all four lines
// in parallel lanes and packs the result with the chosen mode
// ---------------------------------------------------------------------------
// stages: the decide stage registers each accepted request, then the lane stage registers the result and out_valid
// throughput: one segment per clock while out_ready holds; each stage holds one request and moves
//   whenever the stage after it is empty or being drained
// reset: synchronous active-low rst_n clears both stage valid flags only;
//   pixel and decision registers are not reset
`default_nettype none

module luma_deblocking_edge_filter #(
  parameter int PIXEL_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_line0_p,
  input  wire logic [31:0] in_line0_q,
  input  wire logic [31:0] in_line1_p,
  input  wire logic [31:0] in_line1_q,
  input  wire logic [31:0] in_line2_p,
  input  wire logic [31:0] in_line2_q,
  input  wire logic [31:0] in_line3_p,
  input  wire logic [31:0] in_line3_q,
  input  wire logic [6:0]  in_beta_threshold,
  input  wire logic [4:0]  in_clip_threshold,
  input  wire logic        in_keep_p,
  input  wire logic        in_keep_q,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_line0_p,
  output logic [31:0]      out_line0_q,
  output logic [31:0]      out_line1_p,
  output logic [31:0]      out_line1_q,
  output logic [31:0]      out_line2_p,
  output logic [31:0]      out_line2_q,
  output logic [31:0]      out_line3_p,
  output logic [31:0]      out_line3_q,
  output logic [1:0]       out_filter_mode
);

  // thresholds scale with pixel depth
  localparam int SH = PIXEL_BITS - 8;
  // signed working width: covers ten tc and the widest beta at any depth
  localparam int CW = (PIXEL_BITS + 3 > 16) ? PIXEL_BITS + 3 : 16;

  localparam int NL = ldf_pkg::LANES;

  // ---- input side: thresholds scaled and decision taken on the fly ----
  logic [CW-1:0]        beta_u, tc_u;
  ldf_pkg::dec_t        dec_in;
  logic [31:0]          in_p [NL];
  logic [31:0]          in_q [NL];

  assign beta_u = CW'(in_beta_threshold) << SH;
  assign tc_u   = CW'(in_clip_threshold) << SH;

  assign in_p[0] = in_line0_p;
  assign in_q[0] = in_line0_q;
  assign in_p[1] = in_line1_p;
  assign in_q[1] = in_line1_q;
  assign in_p[2] = in_line2_p;
  assign in_q[2] = in_line2_q;
  assign in_p[3] = in_line3_p;
  assign in_q[3] = in_line3_q;

  ldf_decide #(.CW(CW)) u_decide (
    .line0_p (in_line0_p),
    .line0_q (in_line0_q),
    .line3_p (in_line3_p),
    .line3_q (in_line3_q),
    .beta    ($signed(beta_u)),
    .tc      ($signed(tc_u)),
    .dec     (dec_in)
  );

  // ---- stage 1: segment pixels plus decision ----
  logic                 s1_valid_r, s1_valid_nxt;
  logic [31:0]          s1_p_r [NL];
  logic [31:0]          s1_q_r [NL];
  logic signed [CW-1:0] s1_tc_r;
  ldf_pkg::dec_t        s1_dec_r;
  logic                 s1_keep_p_r, s1_keep_q_r;

  // ---- stage 2: output register ----
  logic                 s2_valid_r, s2_valid_nxt;
  logic [31:0]          s2_p_r [NL];
  logic [31:0]          s2_q_r [NL];
  ldf_pkg::mode_t       s2_mode_r;

  logic                 s2_adv;   // output register can take a request
  logic                 in_acc;

  assign s2_adv   = !s2_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_ready ? in_valid : s1_valid_r;
    s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // capture the request with its decision
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < NL; i++) begin
        s1_p_r[i] <= in_p[i];
        s1_q_r[i] <= in_q[i];
      end
      s1_tc_r     <= $signed(tc_u);
      s1_dec_r    <= dec_in;
      s1_keep_p_r <= in_keep_p;
      s1_keep_q_r <= in_keep_q;
    end
  end

  // ---- filter lanes, one per line, all sharing the segment decision ----
  logic [31:0] lane_p [NL];
  logic [31:0] lane_q [NL];

  for (genvar g = 0; g < NL; g++) begin : g_lane
    ldf_lane #(.CW(CW)) u_lane (
      .p_in   (s1_p_r[g]),
      .q_in   (s1_q_r[g]),
      .tc     (s1_tc_r),
      .dec    (s1_dec_r),
      .keep_p (s1_keep_p_r),
      .keep_q (s1_keep_q_r),
      .p_out  (lane_p[g]),
      .q_out  (lane_q[g])
    );
  end

  // merge: lane results and the segment mode into the output register
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      for (int i = 0; i < NL; i++) begin
        s2_p_r[i] <= lane_p[i];
        s2_q_r[i] <= lane_q[i];
      end
      s2_mode_r <= s1_dec_r.mode;
    end
  end

  assign out_valid       = s2_valid_r;
  assign out_line0_p     = s2_p_r[0];
  assign out_line0_q     = s2_q_r[0];
  assign out_line1_p     = s2_p_r[1];
  assign out_line1_q     = s2_q_r[1];
  assign out_line2_p     = s2_p_r[2];
  assign out_line2_q     = s2_q_r[2];
  assign out_line3_p     = s2_p_r[3];
  assign out_line3_q     = s2_q_r[3];
  assign out_filter_mode = s2_mode_r;

  // ---- assertions ----

  // no request is taken while both stages are full and the output stalls
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_valid_r && !out_ready) |-> !in_ready)
    else $error("request accepted into a full pipeline");

  // a result only appears after stage 1 held a request
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(s2_valid_r) |-> $past(s1_valid_r))
    else $error("result without a request in stage 1");

  // unfiltered segments pass through untouched
  a_none_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s1_valid_r && s1_dec_r.mode == ldf_pkg::MODE_NONE) |=>
      (out_line0_p == $past(s1_p_r[0]) && out_line3_q == $past(s1_q_r[3])))
    else $error("unfiltered segment changed");

  // both sides protected: pixels come back unchanged
  a_keep_both: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && s1_valid_r && s1_keep_p_r && s1_keep_q_r) |=>
      (out_line1_p == $past(s1_p_r[1]) && out_line2_q == $past(s1_q_r[2])))
    else $error("protected pixels changed");

endmodule

`default_nettype wire

[design/ldf_decide.sv]
// ---------------------------------------------------------------------------
// ldf_decide: segment decision
// uses lines 0 and 3 to pick no, normal or strong filtering and the
// second-pixel enables of the normal filter
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_decide #(
  parameter int CW = 16
) (
  input  wire logic [31:0]          line0_p,
  input  wire logic [31:0]          line0_q,
  input  wire logic [31:0]          line3_p,
  input  wire logic [31:0]          line3_q,
  input  wire logic signed [CW-1:0] beta,
  input  wire logic signed [CW-1:0] tc,
  output ldf_pkg::dec_t             dec
);

  localparam logic signed [CW-1:0] K1 = 1;

  function automatic logic signed [CW-1:0] ext8(input logic [7:0] v);
    ext8 = $signed({{(CW-8){1'b0}}, v});
  endfunction

  function automatic logic signed [CW-1:0] sabs(input logic signed [CW-1:0] v);
    sabs = v[CW-1] ? -v : v;
  endfunction

  // absolute second difference of the three pixels nearest the edge
  function automatic logic signed [CW-1:0] curv(input logic [31:0] w);
    logic signed [CW-1:0] x0, x1, x2;
    x0 = ext8(w[7:0]);
    x1 = ext8(w[15:8]);
    x2 = ext8(w[23:16]);
    curv = sabs(x2 - (x1 <<< 1) + x0);
  endfunction

  // flatness of one side: distance from its outer pixel to the pixel nearest the edge
  function automatic logic signed [CW-1:0] flat(input logic [31:0] w);
    flat = sabs(ext8(w[31:24]) - ext8(w[7:0]));
  endfunction

  logic signed [CW-1:0] dp0, dq0, dp3, dq3, d0, d3;
  logic signed [CW-1:0] b3, b2, tc25, side;
  logic                 filt, strong_ok;

  always_comb begin
    dp0  = curv(line0_p);
    dq0  = curv(line0_q);
    dp3  = curv(line3_p);
    dq3  = curv(line3_q);
    d0   = dp0 + dq0;
    d3   = dp3 + dq3;
    b3   = beta >>> 3;
    b2   = beta >>> 2;
    tc25 = ((tc <<< 2) + tc + K1) >>> 1;
    side = (beta + (beta >>> 1)) >>> 3;
    filt = (d0 + d3) < beta;
    strong_ok = ((flat(line0_p) + flat(line0_q)) < b3) &&
                (sabs(ext8(line0_p[7:0]) - ext8(line0_q[7:0])) < tc25) &&
                ((flat(line3_p) + flat(line3_q)) < b3) &&
                (sabs(ext8(line3_p[7:0]) - ext8(line3_q[7:0])) < tc25) &&
                ((d0 <<< 1) < b2) && ((d3 <<< 1) < b2);
  end

  always_comb begin
    priority if (!filt) begin
      dec.mode = ldf_pkg::MODE_NONE;
    end else if (strong_ok) begin
      dec.mode = ldf_pkg::MODE_STRONG;
    end else begin
      dec.mode = ldf_pkg::MODE_NORMAL;
    end
    dec.two_p = (dp0 + dp3) < side;
    dec.two_q = (dq0 + dq3) < side;
  end

endmodule

`default_nettype wire

[design/ldf_lane.sv]
// ---------------------------------------------------------------------------
// ldf_lane: one line of the edge filter
// computes strong and normal results for one line and picks by decision
// ---------------------------------------------------------------------------
`default_nettype none

module ldf_lane #(
  parameter int CW = 16
) (
  input  wire logic [31:0]          p_in,
  input  wire logic [31:0]          q_in,
  input  wire logic signed [CW-1:0] tc,
  input  wire ldf_pkg::dec_t        dec,
  input  wire logic                 keep_p,
  input  wire logic                 keep_q,
  output logic [31:0]               p_out,
  output logic [31:0]               q_out
);

  localparam logic signed [CW-1:0] K1 = 1;
  localparam logic signed [CW-1:0] K2 = 2;
  localparam logic signed [CW-1:0] K4 = 4;
  localparam logic signed [CW-1:0] K8 = 8;

  function automatic logic signed [CW-1:0] ext8(input logic [7:0] v);
    ext8 = $signed({{(CW-8){1'b0}}, v});
  endfunction

  function automatic logic signed [CW-1:0] clip3(input logic signed [CW-1:0] v,
                                                 input logic signed [CW-1:0] lo,
                                                 input logic signed [CW-1:0] hi);
    if (v < lo) begin
      clip3 = lo;
    end else if (v > hi) begin
      clip3 = hi;
    end else begin
      clip3 = v;
    end
  endfunction

  function automatic logic [7:0] clip_pix(input logic signed [CW-1:0] v);
    if (v[CW-1]) begin
      clip_pix = 8'h00;
    end else if (v > ext8(ldf_pkg::PIX_MAX)) begin
      clip_pix = ldf_pkg::PIX_MAX;
    end else begin
      clip_pix = v[7:0];
    end
  endfunction

  logic signed [CW-1:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic signed [CW-1:0] t2, tc10, th, e0, e1, dl_raw, dl_abs, dl, hp, hq;
  logic signed [CW-1:0] sp0, sp1, sp2, sq0, sq1, sq2;
  logic [7:0]           st_p0, st_p1, st_p2, st_q0, st_q1, st_q2;
  logic [7:0]           nm_p0, nm_p1, nm_q0, nm_q1;
  logic                 skip;

  always_comb begin
    a0 = ext8(p_in[7:0]);
    a1 = ext8(p_in[15:8]);
    a2 = ext8(p_in[23:16]);
    a3 = ext8(p_in[31:24]);
    b0 = ext8(q_in[7:0]);
    b1 = ext8(q_in[15:8]);
    b2 = ext8(q_in[23:16]);
    b3 = ext8(q_in[31:24]);

    // strong filter, each tap clipped to twice tc around its old value
    t2  = tc <<< 1;
    sp0 = (a2 + (a1 <<< 1) + (a0 <<< 1) + (b0 <<< 1) + b1 + K4) >>> 3;
    sp1 = (a2 + a1 + a0 + b0 + K2) >>> 2;
    sp2 = ((a3 <<< 1) + (a2 <<< 1) + a2 + a1 + a0 + b0 + K4) >>> 3;
    sq0 = (a1 + (a0 <<< 1) + (b0 <<< 1) + (b1 <<< 1) + b2 + K4) >>> 3;
    sq1 = (a0 + b0 + b1 + b2 + K2) >>> 2;
    sq2 = ((b3 <<< 1) + (b2 <<< 1) + b2 + b1 + b0 + a0 + K4) >>> 3;
    st_p0 = clip_pix(clip3(sp0, a0 - t2, a0 + t2));
    st_p1 = clip_pix(clip3(sp1, a1 - t2, a1 + t2));
    st_p2 = clip_pix(clip3(sp2, a2 - t2, a2 + t2));
    st_q0 = clip_pix(clip3(sq0, b0 - t2, b0 + t2));
    st_q1 = clip_pix(clip3(sq1, b1 - t2, b1 + t2));
    st_q2 = clip_pix(clip3(sq2, b2 - t2, b2 + t2));

    // normal filter
    e0     = b0 - a0;
    e1     = b1 - a1;
    dl_raw = ((e0 <<< 3) + e0 - ((e1 <<< 1) + e1) + K8) >>> 4;
    dl_abs = dl_raw[CW-1] ? -dl_raw : dl_raw;
    tc10   = (tc <<< 3) + (tc <<< 1);
    skip   = dl_abs >= tc10;
    dl     = clip3(dl_raw, -tc, tc);
    th     = tc >>> 1;
    hp     = (((a2 + a0 + K1) >>> 1) - a1 + dl) >>> 1;
    hq     = (((b2 + b0 + K1) >>> 1) - b1 - dl) >>> 1;
    nm_p0  = clip_pix(a0 + dl);
    nm_q0  = clip_pix(b0 - dl);
    nm_p1  = clip_pix(a1 + clip3(hp, -th, th));
    nm_q1  = clip_pix(b1 + clip3(hq, -th, th));
  end

  always_comb begin
    p_out = p_in;
    q_out = q_in;
    unique case (dec.mode)
      ldf_pkg::MODE_STRONG: begin
        if (!keep_p) begin
          p_out = {p_in[31:24], st_p2, st_p1, st_p0};
        end
        if (!keep_q) begin
          q_out = {q_in[31:24], st_q2, st_q1, st_q0};
        end
      end
      ldf_pkg::MODE_NORMAL: begin
        if (!skip && !keep_p) begin
          p_out[7:0] = nm_p0;
          if (dec.two_p) begin
            p_out[15:8] = nm_p1;
          end
        end
        if (!skip && !keep_q) begin
          q_out[7:0] = nm_q0;
          if (dec.two_q) begin
            q_out[15:8] = nm_q1;
          end
        end
      end
      default: begin
        p_out = p_in;
        q_out = q_in;
      end
    endcase
  end

endmodule

`default_nettype wire
